FILE: design/sld_pkg.sv
// shared types, constants and helpers for the sync/length frame deframer
package sld_pkg;

	localparam int unsigned SyncLen    = 5;
	localparam int unsigned HeaderLen  = 15;
	localparam logic [3:0]  LenLoPos   = 4'd5;
	localparam logic [3:0]  LenHiPos   = 4'd6;
	localparam logic [3:0]  HeaderLast = 4'(HeaderLen - 1);
	localparam logic [3:0]  HeaderFirst = 4'(SyncLen);
	localparam logic [2:0]  SyncDone   = 3'(SyncLen);

	localparam logic [15:0] MaxLenReset = 16'd4000;

	localparam int unsigned AddrW   = 3;
	localparam logic [AddrW-1:0] RegMaxLen = 3'd0;

	localparam logic [7:0] SyncB0 = 8'hFF;
	localparam logic [7:0] SyncB1 = 8'hA5;
	localparam logic [7:0] SyncB2 = 8'hAA;
	localparam logic [7:0] SyncB3 = 8'h5A;
	localparam logic [7:0] SyncB4 = 8'hFF;

	typedef struct packed {
		logic [15:0] frame_length;
		logic        frame_end;
		logic [7:0]  payload_byte;
	} res_t;

	function automatic logic [7:0] sync_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = SyncB0;
			3'd1:    b = SyncB1;
			3'd2:    b = SyncB2;
			3'd3:    b = SyncB3;
			3'd4:    b = SyncB4;
			default: b = SyncB0;
		endcase
		return b;
	endfunction

endpackage

FILE: design/sld_cfg.sv
// apb register file holding the payload length limit
module sld_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sld_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [15:0]                max_len
);
	import sld_pkg::*;

	logic [15:0] max_len_q;
	logic        hit;

	assign pready  = 1'b1;
	assign hit     = (paddr[AddrW-1:2] == RegMaxLen[AddrW-1:2]);
	assign max_len = max_len_q;
	assign prdata  = hit ? {16'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (psel && penable && pwrite && pready && hit) begin
			max_len_q <= pwdata[15:0];
		end
	end

endmodule

FILE: design/sld_parser.sv
// frame state machine: sync hunt, header count and payload emit
module sld_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [7:0]         rx_byte,
	input  logic [15:0]        max_len,
	output logic               res_valid,
	output sld_pkg::res_t      res
);
	import sld_pkg::*;

	typedef enum logic [1:0] {
		HUNT    = 2'd0,
		HEADER  = 2'd1,
		PAYLOAD = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  sync_q, sync_d;
	logic [3:0]  hpos_q, hpos_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] cnt_inc;
	logic [2:0]  sync_idx;
	logic        last;

	assign cnt_inc  = cnt_q + 16'd1;
	assign last     = (cnt_inc == len_q);
	assign sync_idx = (sync_q >= SyncDone) ? 3'd0 : sync_q;

	always_comb begin
		phase_d   = phase_q;
		sync_d    = sync_q;
		hpos_d    = hpos_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		res_valid = 1'b0;
		res.payload_byte = rx_byte;
		res.frame_end    = last;
		res.frame_length = len_q;
		unique case (phase_q)
			HEADER: begin
				if (hpos_q == LenLoPos) begin
					len_d = {len_q[15:8], rx_byte};
				end else if (hpos_q == LenHiPos) begin
					len_d = {rx_byte, len_q[7:0]};
				end
				if (hpos_q >= HeaderLast) begin
					hpos_d = 4'd0;
					sync_d = 3'd0;
					if (len_q != 16'd0 && len_q <= max_len) begin
						phase_d = PAYLOAD;
						cnt_d   = 16'd0;
					end else begin
						phase_d = HUNT;
					end
				end else begin
					hpos_d = hpos_q + 4'd1;
				end
			end
			PAYLOAD: begin
				res_valid = 1'b1;
				cnt_d     = cnt_inc;
				if (last) begin
					phase_d = HUNT;
					cnt_d   = 16'd0;
					sync_d  = 3'd0;
				end
			end
			default: begin
				phase_d = HUNT;
				if (rx_byte == sync_byte(sync_idx)) begin
					if (sync_idx + 3'd1 == SyncDone) begin
						phase_d = HEADER;
						hpos_d  = HeaderFirst;
						sync_d  = 3'd0;
					end else begin
						sync_d = sync_idx + 3'd1;
					end
				end else begin
					sync_d = (rx_byte == SyncB0) ? 3'd1 : 3'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT;
			sync_q  <= 3'd0;
			hpos_q  <= 4'd0;
			len_q   <= 16'd0;
			cnt_q   <= 16'd0;
		end else if (en) begin
			phase_q <= phase_d;
			sync_q  <= sync_d;
			hpos_q  <= hpos_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: design/sync_length_frame_deframer_core.sv
// top level of the sync/length frame deframer
//
// s_axis carries one received byte per word; the block hunts for the sync
// FF A5 AA 5A FF, counts off the rest of a 15-byte header, takes the
// little-endian payload length from header bytes 5 and 6 and then sends
// each payload byte on m_axis, with tlast on the final byte of the frame.
// Headers with a zero length or one above the apb limit register are
// dropped. No word comes out for sync or header bytes.
// A byte is registered on input and its result is registered on output;
// one byte is taken every cycle while the output is taken or empty.
// When the receiver stalls, the output word holds and one more byte may
// wait in the input register; after that s_tready drops.
// Reset clears both register valid flags, returns to sync hunt and sets the limit
// to 4000. Write the limit only while no frame is in flight.
module sync_length_frame_deframer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // frame_length, payload_byte
	output logic                       m_tlast,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sld_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import sld_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	res_t        out_q;
	logic        advance;
	logic        res_valid;
	res_t        res;
	logic [15:0] max_len;

	sld_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_len (max_len)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	sld_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && advance),
		.rx_byte   (byte_s1),
		.max_len   (max_len),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.frame_length, out_q.payload_byte};
	assign m_tlast  = out_q.frame_end;

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:8] != 16'd0))
		else $error("output word with zero frame length");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_out_from_parser: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !(valid_s1 && res_valid)) |=> !out_valid_q)
		else $error("output word appeared without a parser result");

endmodule
